@@ rtl/core/srws_pkg.sv @@
package srws_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_STATUS  = 2'd1,
        OP_ERROR   = 2'd2
    } op_t;

    // Controller actions ordered by the sequencer
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ENABLE  = 3'd1,
        ACT_START   = 3'd2,
        ACT_SEND    = 3'd3,
        ACT_RESTART = 3'd4,
        ACT_NACK    = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    // One input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  slave_address;
        logic [7:0]  command_code;
        logic        periph_enabled;
        logic        stop_pending;
        logic        bus_busy;
        logic        start_sent;
        logic        address_acked;
        logic        tx_empty;
        logic        byte_done;
        logic        stop_seen;
        logic [15:0] rx_word;
    } item_t;

    // One result item
    typedef struct packed {
        logic        accepted;
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic        reinit;
        logic        word_valid;
        logic [15:0] word_out;
    } result_t;

    // Pipeline flow control between the stages
    typedef struct packed {
        logic fire;     // input stage hands its request to the sequencer
        logic advance;  // result stage can take a new result
    } flow_t;

endpackage

@@ rtl/core/srws_if.sv @@
// Input request channel
interface srws_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [6:0]  slave_address;
    logic [7:0]  command_code;
    logic        periph_enabled;
    logic        stop_pending;
    logic        bus_busy;
    logic        start_sent;
    logic        address_acked;
    logic        tx_empty;
    logic        byte_done;
    logic        stop_seen;
    logic [15:0] rx_word;

    modport source (
        output valid, operation, slave_address, command_code, periph_enabled,
               stop_pending, bus_busy, start_sent, address_acked, tx_empty,
               byte_done, stop_seen, rx_word,
        input  ready
    );
    modport sink (
        input  valid, operation, slave_address, command_code, periph_enabled,
               stop_pending, bus_busy, start_sent, address_acked, tx_empty,
               byte_done, stop_seen, rx_word,
        output ready
    );
endinterface

// Result channel
interface srws_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic        reinit;
    logic        word_valid;
    logic [15:0] word_out;

    modport source (
        output valid, accepted, action, tx_byte, reinit, word_valid, word_out,
        input  ready
    );
    modport sink (
        input  valid, accepted, action, tx_byte, reinit, word_valid, word_out,
        output ready
    );
endinterface

@@ rtl/core/srws_in_stage.sv @@
module srws_in_stage
    import srws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    srws_req_if.sink   req,
    input  logic       advance,
    output logic       fire,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Stage is free when empty or when its request moves on this cycle
    assign fire      = valid_reg && advance;
    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;
    assign valid_next = take ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Request payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation      <= req.operation;
            item_reg.slave_address  <= req.slave_address;
            item_reg.command_code   <= req.command_code;
            item_reg.periph_enabled <= req.periph_enabled;
            item_reg.stop_pending   <= req.stop_pending;
            item_reg.bus_busy       <= req.bus_busy;
            item_reg.start_sent     <= req.start_sent;
            item_reg.address_acked  <= req.address_acked;
            item_reg.tx_empty       <= req.tx_empty;
            item_reg.byte_done      <= req.byte_done;
            item_reg.stop_seen      <= req.stop_seen;
            item_reg.rx_word        <= req.rx_word;
        end
    end

    assign item = item_reg;

endmodule

@@ rtl/core/srws_fsm.sv @@
module srws_fsm
    import srws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [2:0] {
        PH_FREE         = 3'd0,
        PH_WAIT_START   = 3'd1,
        PH_WAIT_ADDR_W  = 3'd2,
        PH_WAIT_CMD     = 3'd3,
        PH_WAIT_RESTART = 3'd4,
        PH_WAIT_ADDR_R  = 3'd5,
        PH_WAIT_DATA    = 3'd6
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       active_reg;
    logic       active_next;
    logic [6:0] addr_reg;
    logic [6:0] addr_next;
    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    result_t    res;

    // One step of the sequencer for the request in the input stage
    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        res         = '0;
        res.action  = ACT_NONE;

        case (op_t'(item.operation))
            OP_REQUEST:
            begin
                if (!item.periph_enabled)
                begin
                    res.action = ACT_ENABLE;
                end
                else if (!active_reg && !item.stop_pending)
                begin
                    if (item.bus_busy)
                    begin
                        res.reinit = 1'b1;
                    end
                    else
                    begin
                        active_next  = 1'b1;
                        phase_next   = PH_WAIT_START;
                        addr_next    = item.slave_address;
                        cmd_next     = item.command_code;
                        res.action   = ACT_START;
                        res.accepted = 1'b1;
                    end
                end
            end
            OP_STATUS:
            begin
                if (active_reg)
                begin
                    case (phase_reg)
                        PH_WAIT_START:
                        begin
                            if (item.start_sent)
                            begin
                                phase_next  = PH_WAIT_ADDR_W;
                                res.action  = ACT_SEND;
                                res.tx_byte = {addr_reg, 1'b0};
                            end
                        end
                        PH_WAIT_ADDR_W:
                        begin
                            if (item.address_acked)
                            begin
                                phase_next  = PH_WAIT_CMD;
                                res.action  = ACT_SEND;
                                res.tx_byte = cmd_reg;
                            end
                        end
                        PH_WAIT_CMD:
                        begin
                            if (item.tx_empty)
                            begin
                                phase_next = PH_WAIT_RESTART;
                                res.action = ACT_RESTART;
                            end
                        end
                        PH_WAIT_RESTART:
                        begin
                            if (item.start_sent)
                            begin
                                phase_next  = PH_WAIT_ADDR_R;
                                res.action  = ACT_SEND;
                                res.tx_byte = {addr_reg, 1'b1};
                            end
                        end
                        PH_WAIT_ADDR_R:
                        begin
                            if (item.address_acked)
                            begin
                                phase_next = PH_WAIT_DATA;
                                res.action = ACT_NACK;
                            end
                        end
                        PH_WAIT_DATA:
                        begin
                            if (item.byte_done)
                            begin
                                phase_next     = PH_FREE;
                                active_next    = 1'b0;
                                res.action     = ACT_STOP;
                                res.word_valid = 1'b1;
                                res.word_out   = item.rx_word;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_FREE;
                        end
                    endcase
                end
                // A stop flag is a bus fault for the master
                if (item.stop_seen)
                begin
                    res.reinit  = 1'b1;
                    phase_next  = PH_FREE;
                    active_next = 1'b0;
                end
            end
            OP_ERROR:
            begin
                res.reinit  = 1'b1;
                phase_next  = PH_FREE;
                active_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FREE;
            active_reg <= 1'b0;
            addr_reg   <= '0;
            cmd_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign result = res;

endmodule

@@ rtl/core/srws_out_stage.sv @@
module srws_out_stage
    import srws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  result_t    result,
    output logic       advance,
    srws_rsp_if.source rsp
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new result when empty or when the held one is taken
    assign advance    = !valid_reg || rsp.ready;
    assign valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload capture
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.accepted   = result_reg.accepted;
    assign rsp.action     = result_reg.action;
    assign rsp.tx_byte    = result_reg.tx_byte;
    assign rsp.reinit     = result_reg.reinit;
    assign rsp.word_valid = result_reg.word_valid;
    assign rsp.word_out   = result_reg.word_out;

endmodule

@@ rtl/core/smbus_read_word_sequencer.sv @@
// SMBus Read Word master sequencer.
// A request accepted into the input register passes the phase logic and is
// offered once the result register captures it. Throughput: one request per
// cycle unless rsp.ready stalls; the input register, one pass of the phase
// logic and the result register let requests follow back to back.
// Reset (rst_n, async, active low): both stages empty, phase free, no
// transaction, latched address and command cleared.
module smbus_read_word_sequencer
    import srws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    srws_req_if.sink   req,
    srws_rsp_if.source rsp
);

    flow_t   flow;
    item_t   item;
    result_t result;

    // Input register
    srws_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (flow.advance),
        .fire    (flow.fire),
        .item    (item)
    );

    // Phase logic and transaction state
    srws_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (flow.fire),
        .item   (item),
        .result (result)
    );

    // Result register
    srws_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (flow.fire),
        .result  (result),
        .advance (flow.advance),
        .rsp     (rsp)
    );

endmodule

@@ rtl/core/srws_checker.sv @@
module srws_checker
    import srws_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_accepted,
    input logic [2:0]  rsp_action,
    input logic [7:0]  rsp_tx_byte,
    input logic        rsp_reinit,
    input logic        rsp_word_valid,
    input logic [15:0] rsp_word_out
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // A delivered word always comes with the stop order
    a_word_stop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word_valid |-> rsp_action == ACT_STOP)
        else $error("word delivered without stop");

    // An accepted request orders a start and never a reinit
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_accepted |-> rsp_action == ACT_START && !rsp_reinit)
        else $error("accepted request without start");

    // A transmit byte only with the send order
    a_tx_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_tx_byte != 8'd0 |-> rsp_action == ACT_SEND)
        else $error("tx byte outside send");

    // No word data unless a word is delivered
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word_valid |-> rsp_word_out == 16'd0)
        else $error("stray word data");

endmodule

bind smbus_read_word_sequencer srws_checker u_srws_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_accepted   (rsp.accepted),
    .rsp_action     (rsp.action),
    .rsp_tx_byte    (rsp.tx_byte),
    .rsp_reinit     (rsp.reinit),
    .rsp_word_valid (rsp.word_valid),
    .rsp_word_out   (rsp.word_out)
);

@@ test/smbus_read_word_sequencer_tb.sv @@
`timescale 1ns / 100ps

module smbus_read_word_sequencer_tb;
    import srws_pkg::*;

    // Sequencer phases, as tracked by the predictor
    typedef enum logic [2:0] {
        PH_FREE         = 3'd0,
        PH_WAIT_START   = 3'd1,
        PH_WAIT_ADDR_W  = 3'd2,
        PH_WAIT_CMD     = 3'd3,
        PH_WAIT_RESTART = 3'd4,
        PH_WAIT_ADDR_R  = 3'd5,
        PH_WAIT_DATA    = 3'd6
    } phase_t;

    // Operation code with no meaning; the block ignores it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    srws_req_if req_ch ();
    srws_rsp_if rsp_ch ();

    smbus_read_word_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state
    phase_t     seq_phase;
    logic       txn_active;
    logic [6:0] latched_addr;
    logic [7:0] latched_cmd;

    result_t pending_responses[$];
    int      error_count;
    int      items_sent;
    int      send_idle_pct;
    int      recv_idle_pct;

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Bit-exact model of one request step; updates the predictor state
    function automatic result_t sequence_step(item_t it);
        result_t r;
        r = '0;
        case (it.operation)
            OP_REQUEST:
            begin
                if (!it.periph_enabled)
                    r.action = ACT_ENABLE;
                else if (!txn_active && !it.stop_pending)
                begin
                    if (it.bus_busy)
                        r.reinit = 1'b1;
                    else
                    begin
                        txn_active   = 1'b1;
                        seq_phase    = PH_WAIT_START;
                        latched_addr = it.slave_address;
                        latched_cmd  = it.command_code;
                        r.action     = ACT_START;
                        r.accepted   = 1'b1;
                    end
                end
            end
            OP_STATUS:
            begin
                if (txn_active)
                begin
                    case (seq_phase)
                        PH_WAIT_START:
                            if (it.start_sent)
                            begin
                                seq_phase = PH_WAIT_ADDR_W;
                                r.action  = ACT_SEND;
                                r.tx_byte = {latched_addr, 1'b0};
                            end
                        PH_WAIT_ADDR_W:
                            if (it.address_acked)
                            begin
                                seq_phase = PH_WAIT_CMD;
                                r.action  = ACT_SEND;
                                r.tx_byte = latched_cmd;
                            end
                        PH_WAIT_CMD:
                            if (it.tx_empty)
                            begin
                                seq_phase = PH_WAIT_RESTART;
                                r.action  = ACT_RESTART;
                            end
                        PH_WAIT_RESTART:
                            if (it.start_sent)
                            begin
                                seq_phase = PH_WAIT_ADDR_R;
                                r.action  = ACT_SEND;
                                r.tx_byte = {latched_addr, 1'b1};
                            end
                        PH_WAIT_ADDR_R:
                            if (it.address_acked)
                            begin
                                seq_phase = PH_WAIT_DATA;
                                r.action  = ACT_NACK;
                            end
                        PH_WAIT_DATA:
                            if (it.byte_done)
                            begin
                                seq_phase    = PH_FREE;
                                txn_active   = 1'b0;
                                r.action     = ACT_STOP;
                                r.word_valid = 1'b1;
                                r.word_out   = it.rx_word;
                            end
                        default:
                            seq_phase = PH_FREE;
                    endcase
                end
                // stray stop is a fault for a master
                if (it.stop_seen)
                begin
                    r.reinit   = 1'b1;
                    seq_phase  = PH_FREE;
                    txn_active = 1'b0;
                end
            end
            OP_ERROR:
            begin
                r.reinit   = 1'b1;
                seq_phase  = PH_FREE;
                txn_active = 1'b0;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Send one request, with random idle cycles ahead of it
    task automatic send_item(item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= it.operation;
        req_ch.slave_address  <= it.slave_address;
        req_ch.command_code   <= it.command_code;
        req_ch.periph_enabled <= it.periph_enabled;
        req_ch.stop_pending   <= it.stop_pending;
        req_ch.bus_busy       <= it.bus_busy;
        req_ch.start_sent     <= it.start_sent;
        req_ch.address_acked  <= it.address_acked;
        req_ch.tx_empty       <= it.tx_empty;
        req_ch.byte_done      <= it.byte_done;
        req_ch.stop_seen      <= it.stop_seen;
        req_ch.rx_word        <= it.rx_word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_responses.push_back(sequence_step(it));
        items_sent++;
    endtask

    // Quiet request: controller enabled, no flags
    function automatic item_t plain_item(logic [1:0] op);
        item_t it;
        it                = '0;
        it.operation      = op;
        it.periph_enabled = 1'b1;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.operation      = 2'($urandom_range(0, 3));
        it.slave_address  = 7'($urandom);
        it.command_code   = 8'($urandom);
        it.periph_enabled = 1'($urandom);
        it.stop_pending   = 1'($urandom);
        it.bus_busy       = 1'($urandom);
        it.start_sent     = 1'($urandom);
        it.address_acked  = 1'($urandom);
        it.tx_empty       = 1'($urandom);
        it.byte_done      = 1'($urandom);
        it.stop_seen      = 1'($urandom);
        it.rx_word        = 16'($urandom);
        return it;
    endfunction

    // Status event that moves the sequencer out of its current phase
    function automatic item_t advance_event(logic [15:0] word);
        item_t it;
        it         = plain_item(OP_STATUS);
        it.rx_word = word;
        case (seq_phase)
            PH_WAIT_START, PH_WAIT_RESTART: it.start_sent    = 1'b1;
            PH_WAIT_ADDR_W, PH_WAIT_ADDR_R: it.address_acked = 1'b1;
            PH_WAIT_CMD:                    it.tx_empty      = 1'b1;
            default:                        it.byte_done     = 1'b1;
        endcase
        return it;
    endfunction

    // Gating of new requests while idle, odd codes, events with no transaction
    task automatic test_request_gating();
        item_t it;
        it = plain_item(OP_REQUEST);
        it.periph_enabled = 1'b0;
        send_item(it);
        it = plain_item(OP_REQUEST);
        it.stop_pending = 1'b1;
        send_item(it);
        it = plain_item(OP_REQUEST);
        it.bus_busy = 1'b1;
        send_item(it);
        it = '1;
        it.operation = OP_UNUSED;
        send_item(it);
        it = '1;
        it.operation = OP_STATUS;
        it.stop_seen = 1'b0;
        send_item(it);
        it = plain_item(OP_STATUS);
        it.stop_seen = 1'b1;
        send_item(it);
    endtask

    // Complete read at the top address and command, with rejected requests inside
    task automatic test_full_read();
        item_t it;
        it = plain_item(OP_REQUEST);
        it.slave_address = 7'h7F;
        it.command_code  = 8'hFF;
        send_item(it);
        // no matching flag: nothing happens
        send_item(plain_item(OP_STATUS));
        send_item(advance_event(16'h0));
        // a request mid transaction is refused; disabled controller still asks enable
        send_item(plain_item(OP_REQUEST));
        it = plain_item(OP_REQUEST);
        it.periph_enabled = 1'b0;
        send_item(it);
        repeat (5)
            send_item(advance_event(16'hFFFF));
    endtask

    // Zero address and command; stop flag arrives with the last byte
    task automatic test_stop_and_error();
        item_t it;
        send_item(plain_item(OP_REQUEST));
        repeat (5)
            send_item(advance_event(16'h0));
        it = advance_event(16'h0);
        it.stop_seen = 1'b1;
        send_item(it);
        // stop flag on an event that matches nothing
        send_item(plain_item(OP_REQUEST));
        it = plain_item(OP_STATUS);
        it.stop_seen = 1'b1;
        send_item(it);
        // error event mid transaction
        send_item(plain_item(OP_REQUEST));
        send_item(plain_item(OP_ERROR));
    endtask

    // One read with random content; occasionally broken or disturbed
    task automatic send_read_word();
        item_t it;
        it = random_item();
        it.operation = OP_REQUEST;
        if ($urandom_range(0, 9) != 0)
        begin
            it.periph_enabled = 1'b1;
            it.stop_pending   = 1'b0;
            it.bus_busy       = 1'b0;
        end
        send_item(it);
        while (txn_active)
        begin
            it = random_item();
            it.operation = OP_STATUS;
            it.stop_seen = ($urandom_range(0, 29) == 0);
            case (seq_phase)
                PH_WAIT_START, PH_WAIT_RESTART:
                    it.start_sent = ($urandom_range(0, 4) != 0);
                PH_WAIT_ADDR_W, PH_WAIT_ADDR_R:
                    it.address_acked = ($urandom_range(0, 4) != 0);
                PH_WAIT_CMD:
                    it.tx_empty = ($urandom_range(0, 4) != 0);
                default:
                    it.byte_done = ($urandom_range(0, 4) != 0);
            endcase
            case ($urandom_range(0, 39))
                0:       it.operation = OP_ERROR;
                1:       it.operation = OP_REQUEST;
                2:       it.operation = OP_UNUSED;
                default: ;
            endcase
            send_item(it);
        end
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(random_item());
            else
                send_read_word();
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Response side: random stalls, compare each response with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response with none expected");
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("accepted", 16'(want.accepted), 16'(rsp_ch.accepted));
                check_field("action", 16'(want.action), 16'(rsp_ch.action));
                check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_ch.tx_byte));
                check_field("reinit", 16'(want.reinit), 16'(rsp_ch.reinit));
                check_field("word_valid", 16'(want.word_valid),
                            16'(rsp_ch.word_valid));
                check_field("word_out", want.word_out, rsp_ch.word_out);
            end
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        send_idle_pct = 27;
        recv_idle_pct = 45;
        seq_phase     = PH_FREE;
        txn_active    = 1'b0;
        latched_addr  = '0;
        latched_cmd   = '0;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.operation      <= OP_REQUEST;
        req_ch.slave_address  <= '0;
        req_ch.command_code   <= '0;
        req_ch.periph_enabled <= 1'b0;
        req_ch.stop_pending   <= 1'b0;
        req_ch.bus_busy       <= 1'b0;
        req_ch.start_sent     <= 1'b0;
        req_ch.address_acked  <= 1'b0;
        req_ch.tx_empty       <= 1'b0;
        req_ch.byte_done      <= 1'b0;
        req_ch.stop_seen      <= 1'b0;
        req_ch.rx_word        <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_request_gating();
        test_full_read();
        test_stop_and_error();
        test_random_traffic(300, 27, 45);
        test_random_traffic(300, 45, 27);
        test_random_traffic(300, 0, 0);

        // drain outstanding responses
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
